// ----- rtl/fnf_pkg.sv -----
// Shared widths, latencies and codes of the surface normal frame pipeline.
package fnf_pkg;

    localparam int NRM_W   = 16;   // normal component, Q2.14
    localparam int POS_W   = 32;   // point coordinate, Q16.16
    localparam int EPS_W   = 14;   // solving axis threshold
    localparam int AX_W    = 16;   // axis component, Q2.14
    localparam int PM_W    = 33;   // point coordinate minus one
    localparam int PRD_W   = 49;   // normal times (point minus one)
    localparam int U_W     = 51;   // scaled in-plane direction
    localparam int MS_W    = 30;   // normalized magnitude
    localparam int WV_W    = 31;   // signed normalized vector handed to the cross product
    localparam int XP_W    = 47;   // cross product term
    localparam int T_W     = 48;   // cross product component
    localparam int SQ_W    = 60;   // square of one magnitude
    localparam int SUM_W   = 62;   // sum of squares
    localparam int ACC_W   = 63;   // square root working width
    localparam int ROOT_W  = 31;   // integer square root
    localparam int NUM_W   = 45;   // rounded dividend
    localparam int Q_W     = 15;   // quotient magnitude
    localparam int SQ_STEPS  = 31; // one root bit per stage
    localparam int DIV_STEPS = 15; // one quotient bit per stage
    localparam int LEAD_POS  = 29; // target position of the leading one

    // Normalizer timing: signed vector out after NORM_W_LAT, unit vector after NORM_LAT.
    localparam int NORM_W_LAT = 3;
    localparam int NORM_LAT   = 5 + SQ_STEPS + 1 + DIV_STEPS + 1;

    localparam logic signed [PM_W-1:0] ONE_Q16 = 33'sd65536;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } t_axis;

endpackage

// ----- rtl/frame_from_surface_normal.sv -----
// Top level of the pipeline that builds an orthonormal frame from a surface normal.
//
// The block takes one word per clock cycle and never stalls: o_busy stays low, and every
// word given with i_start returns as one word marked by o_valid. The depth comes from
// the three vector normalizers, each of which holds a 31-stage square root and a 15-stage
// divider producing one bit per stage; the first axis feeds the cross product that the
// second normalizer works on, so two normalizers lie in series. The first axis points
// from the input point towards a second point of its plane (two coordinates at one, the
// third solved along the first of x and y whose magnitude exceeds axis_epsilon, else z),
// the second axis is the normal crossed with the first, and the third is the normalized
// normal. A zero-length vector gives a zero axis. The point passes through as the
// translation. axis_epsilon is written through the cfg channel, which is always ready;
// it should change only when no word is in flight.
module frame_from_surface_normal import fnf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [NRM_W-1:0]  i_normal_x,
    input  logic signed [NRM_W-1:0]  i_normal_y,
    input  logic signed [NRM_W-1:0]  i_normal_z,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [EPS_W-1:0]         i_cfg_axis_epsilon,
    output logic                     o_valid,
    output logic signed [AX_W-1:0]   o_axis1_x,
    output logic signed [AX_W-1:0]   o_axis1_y,
    output logic signed [AX_W-1:0]   o_axis1_z,
    output logic signed [AX_W-1:0]   o_axis2_x,
    output logic signed [AX_W-1:0]   o_axis2_y,
    output logic signed [AX_W-1:0]   o_axis2_z,
    output logic signed [AX_W-1:0]   o_axis3_x,
    output logic signed [AX_W-1:0]   o_axis3_y,
    output logic signed [AX_W-1:0]   o_axis3_z,
    output logic signed [POS_W-1:0]  o_trans_x,
    output logic signed [POS_W-1:0]  o_trans_y,
    output logic signed [POS_W-1:0]  o_trans_z
);

    // Timeline, counted in cycles after the word is taken.
    localparam int U_LAT    = 3;                        // scaled direction registered
    localparam int W_LAT    = U_LAT + NORM_W_LAT;       // shifted first axis available
    localparam int T_LAT    = W_LAT + 2;                // cross product registered
    localparam int A2_LAT   = T_LAT + NORM_LAT;         // second axis ready
    localparam int A1_LAT   = U_LAT + NORM_LAT;         // first axis ready
    localparam int A3_LAT   = 1 + NORM_LAT;             // third axis ready
    localparam int PIPE_LAT = A2_LAT + 1;               // output register

    logic [EPS_W-1:0]          r_axis_epsilon;
    logic [PIPE_LAT-2:0]       r_vld;

    logic signed [NRM_W-1:0]   r_a_nrm [3];
    logic signed [PM_W-1:0]    r_a_pm  [3];
    t_axis                     r_a_k;
    t_axis                     n_a_k;

    logic signed [PRD_W-1:0]   r_b_prod  [3];
    logic signed [PRD_W-1:0]   r_b_cprod [3];
    t_axis                     r_b_k;
    logic                      r_b_kneg;
    logic signed [NRM_W-1:0]   n_b_nk;

    logic signed [U_W-1:0]     r_c_u [3];
    logic signed [U_W-1:0]     n_c_u [3];

    logic signed [WV_W-1:0]    w1 [3];
    logic signed [AX_W-1:0]    a1 [3];
    logic signed [AX_W-1:0]    a2 [3];
    logic signed [AX_W-1:0]    a3 [3];
    logic signed [XP_W-1:0]    r_x_p [6];
    logic signed [T_W-1:0]     r_t [3];
    logic [3*NRM_W-1:0]        nrm_late;
    logic signed [NRM_W-1:0]   nl [3];
    logic [3*AX_W-1:0]         a1_late;
    logic [3*AX_W-1:0]         a3_late;
    logic [3*POS_W-1:0]        pos_late;

    logic [NRM_W:0]            mag_x;
    logic [NRM_W:0]            mag_y;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_epsilon <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_axis_epsilon <= i_cfg_axis_epsilon;
        end
    end

    // Valid bits ride alongside the payload; the last one feeds the output strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[PIPE_LAT-3:0], i_start && !o_busy};
            o_valid <= r_vld[PIPE_LAT-2];
        end
    end

    // Stage A: pick the solving axis, x before y before z; z is the fallback even when small.
    assign mag_x = i_normal_x[NRM_W-1] ? (NRM_W+1)'(-(NRM_W+1)'(i_normal_x))
                                       : (NRM_W+1)'(i_normal_x);
    assign mag_y = i_normal_y[NRM_W-1] ? (NRM_W+1)'(-(NRM_W+1)'(i_normal_y))
                                       : (NRM_W+1)'(i_normal_y);

    always_comb begin
        if (mag_x > (NRM_W+1)'(r_axis_epsilon)) begin
            n_a_k = AX_X;
        end else if (mag_y > (NRM_W+1)'(r_axis_epsilon)) begin
            n_a_k = AX_Y;
        end else begin
            n_a_k = AX_Z;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_nrm[0] <= i_normal_x;
        r_a_nrm[1] <= i_normal_y;
        r_a_nrm[2] <= i_normal_z;
        r_a_pm[0]  <= PM_W'(i_pos_x) - ONE_Q16;
        r_a_pm[1]  <= PM_W'(i_pos_y) - ONE_Q16;
        r_a_pm[2]  <= PM_W'(i_pos_z) - ONE_Q16;
        r_a_k      <= n_a_k;
    end

    // Stage B: every product the direction needs, scaled by the solving component.
    always_comb begin
        case (r_a_k)
            AX_X:    n_b_nk = r_a_nrm[0];
            AX_Y:    n_b_nk = r_a_nrm[1];
            AX_Z:    n_b_nk = r_a_nrm[2];
            default: n_b_nk = r_a_nrm[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_b_prod[i]  <= r_a_nrm[i] * r_a_pm[i];
            r_b_cprod[i] <= n_b_nk * r_a_pm[i];
        end
        r_b_k    <= r_a_k;
        r_b_kneg <= n_b_nk[NRM_W-1];
    end

    // Stage C: assemble the direction and flip it when the solving component is negative.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_c_u[i] = -U_W'(r_b_cprod[i]);
        end
        case (r_b_k)
            AX_X:    n_c_u[0] = U_W'(r_b_prod[1]) + U_W'(r_b_prod[2]);
            AX_Y:    n_c_u[1] = U_W'(r_b_prod[0]) + U_W'(r_b_prod[2]);
            AX_Z:    n_c_u[2] = U_W'(r_b_prod[0]) + U_W'(r_b_prod[1]);
            default: n_c_u[2] = U_W'(r_b_prod[0]) + U_W'(r_b_prod[1]);
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_c_u[i] <= r_b_kneg ? -n_c_u[i] : n_c_u[i];
        end
    end

    fnf_norm #(.W(U_W)) u_norm_a1 (
        .i_clk (i_clk),
        .i_v   (r_c_u),
        .o_w   (w1),
        .o_a   (a1)
    );

    // The normal waits here until the aligned first axis comes out of its normalizer.
    fnf_delay #(.W(3*NRM_W), .D(W_LAT - 1)) u_nrm_dly (
        .i_clk (i_clk),
        .i_d   ({r_a_nrm[0], r_a_nrm[1], r_a_nrm[2]}),
        .o_q   (nrm_late)
    );

    assign nl[0] = nrm_late[2*NRM_W +: NRM_W];
    assign nl[1] = nrm_late[NRM_W +: NRM_W];
    assign nl[2] = nrm_late[0 +: NRM_W];

    // Cross product of the normal with the shifted first axis, products then differences.
    always_ff @(posedge i_clk) begin
        r_x_p[0] <= nl[1] * w1[2];
        r_x_p[1] <= nl[2] * w1[1];
        r_x_p[2] <= nl[2] * w1[0];
        r_x_p[3] <= nl[0] * w1[2];
        r_x_p[4] <= nl[0] * w1[1];
        r_x_p[5] <= nl[1] * w1[0];
        r_t[0]   <= T_W'(r_x_p[0]) - T_W'(r_x_p[1]);
        r_t[1]   <= T_W'(r_x_p[2]) - T_W'(r_x_p[3]);
        r_t[2]   <= T_W'(r_x_p[4]) - T_W'(r_x_p[5]);
    end

    fnf_norm #(.W(T_W)) u_norm_a2 (
        .i_clk (i_clk),
        .i_v   (r_t),
        .o_w   (),
        .o_a   (a2)
    );

    fnf_norm #(.W(NRM_W)) u_norm_a3 (
        .i_clk (i_clk),
        .i_v   (r_a_nrm),
        .o_w   (),
        .o_a   (a3)
    );

    fnf_delay #(.W(3*AX_W), .D(A2_LAT - A1_LAT)) u_a1_dly (
        .i_clk (i_clk),
        .i_d   ({a1[0], a1[1], a1[2]}),
        .o_q   (a1_late)
    );

    fnf_delay #(.W(3*AX_W), .D(A2_LAT - A3_LAT)) u_a3_dly (
        .i_clk (i_clk),
        .i_d   ({a3[0], a3[1], a3[2]}),
        .o_q   (a3_late)
    );

    fnf_delay #(.W(3*POS_W), .D(A2_LAT)) u_pos_dly (
        .i_clk (i_clk),
        .i_d   ({i_pos_x, i_pos_y, i_pos_z}),
        .o_q   (pos_late)
    );

    always_ff @(posedge i_clk) begin
        o_axis1_x <= a1_late[2*AX_W +: AX_W];
        o_axis1_y <= a1_late[AX_W +: AX_W];
        o_axis1_z <= a1_late[0 +: AX_W];
        o_axis2_x <= a2[0];
        o_axis2_y <= a2[1];
        o_axis2_z <= a2[2];
        o_axis3_x <= a3_late[2*AX_W +: AX_W];
        o_axis3_y <= a3_late[AX_W +: AX_W];
        o_axis3_z <= a3_late[0 +: AX_W];
        o_trans_x <= pos_late[2*POS_W +: POS_W];
        o_trans_y <= pos_late[POS_W +: POS_W];
        o_trans_z <= pos_late[0 +: POS_W];
    end

    // The pipeline never holds a word back.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("pipeline reported busy");

    // Unit components never leave the Q2.14 range of one.
    a_axis1_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_axis1_x <= 16'sd16384 && o_axis1_x >= -16'sd16384 &&
                     o_axis1_y <= 16'sd16384 && o_axis1_y >= -16'sd16384 &&
                     o_axis1_z <= 16'sd16384 && o_axis1_z >= -16'sd16384))
        else $error("first axis out of range");

    a_axis2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_axis2_x <= 16'sd16384 && o_axis2_x >= -16'sd16384 &&
                     o_axis2_y <= 16'sd16384 && o_axis2_y >= -16'sd16384 &&
                     o_axis2_z <= 16'sd16384 && o_axis2_z >= -16'sd16384))
        else $error("second axis out of range");

    a_axis3_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_axis3_x <= 16'sd16384 && o_axis3_x >= -16'sd16384 &&
                     o_axis3_y <= 16'sd16384 && o_axis3_y >= -16'sd16384 &&
                     o_axis3_z <= 16'sd16384 && o_axis3_z >= -16'sd16384))
        else $error("third axis out of range");

endmodule

// ----- rtl/fnf_delay.sv -----
// Fixed-length delay line for data that travels beside the arithmetic.
module fnf_delay import fnf_pkg::*; #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [D];

    always_ff @(posedge i_clk) begin
        r_line[0] <= i_d;
        for (int i = 1; i < D; i++) begin
            r_line[i] <= r_line[i-1];
        end
    end

    assign o_q = r_line[D-1];

endmodule

// ----- rtl/fnf_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module fnf_isqrt import fnf_pkg::*; (
    input  logic              i_clk,
    input  logic [SUM_W-1:0]  i_s,
    output logic [ROOT_W-1:0] o_r
);

    logic [ACC_W-1:0] r_s   [SQ_STEPS];
    logic [ACC_W-1:0] r_res [SQ_STEPS];

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
        localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (2 * (SQ_STEPS - 1 - j));
        logic [ACC_W-1:0] s_in;
        logic [ACC_W-1:0] res_in;
        logic [ACC_W-1:0] trial;

        if (j == 0) begin : g_first
            assign s_in   = ACC_W'(i_s);
            assign res_in = '0;
        end else begin : g_next
            assign s_in   = r_s[j-1];
            assign res_in = r_res[j-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (s_in >= trial) begin
                r_s[j]   <= s_in - trial;
                r_res[j] <= (res_in >> 1) + BIT;
            end else begin
                r_s[j]   <= s_in;
                r_res[j] <= res_in >> 1;
            end
        end
    end

    assign o_r = r_res[SQ_STEPS-1][ROOT_W-1:0];

endmodule

// ----- rtl/fnf_div.sv -----
// Pipelined restoring divider for three dividends over one shared divisor.
module fnf_div import fnf_pkg::*; (
    input  logic              i_clk,
    input  logic [NUM_W-1:0]  i_num [3],
    input  logic [ROOT_W-1:0] i_den,
    output logic [Q_W-1:0]    o_q   [3]
);

    logic [NUM_W-1:0]  r_rem [DIV_STEPS][3];
    logic [Q_W-1:0]    r_q   [DIV_STEPS][3];
    logic [ROOT_W-1:0] r_den [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        localparam int B = DIV_STEPS - 1 - j;
        logic [NUM_W-1:0]  rem_in [3];
        logic [Q_W-1:0]    q_in   [3];
        logic [ROOT_W-1:0] den_in;
        logic [NUM_W:0]    trial;

        if (j == 0) begin : g_first
            assign rem_in = i_num;
            assign q_in   = '{default: '0};
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign q_in   = r_q[j-1];
            assign den_in = r_den[j-1];
        end

        assign trial = (NUM_W+1)'(den_in) << B;

        always_ff @(posedge i_clk) begin
            r_den[j] <= den_in;
            for (int l = 0; l < 3; l++) begin
                if ({1'b0, rem_in[l]} >= trial) begin
                    r_rem[j][l] <= NUM_W'({1'b0, rem_in[l]} - trial);
                    r_q[j][l]   <= {q_in[l][Q_W-2:0], 1'b1};
                end else begin
                    r_rem[j][l] <= rem_in[l];
                    r_q[j][l]   <= {q_in[l][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_q = r_q[DIV_STEPS-1];

endmodule

// ----- rtl/fnf_norm.sv -----
// Vector normalizer: magnitude alignment, sum of squares, root and rounded division.
module fnf_norm import fnf_pkg::*; #(
    parameter int W = 16
) (
    input  logic                    i_clk,
    input  logic signed [W-1:0]     i_v [3],
    output logic signed [WV_W-1:0]  o_w [3],
    output logic signed [AX_W-1:0]  o_a [3]
);

    localparam int LZ_W = $clog2(W);
    localparam int XW   = W + MS_W;

    logic [W-1:0]      r_m0 [3];
    logic [2:0]        r_neg0;
    logic [W-1:0]      r_m1 [3];
    logic [2:0]        r_neg1;
    logic [LZ_W-1:0]   r_lead;
    logic              r_nz1;
    logic [MS_W-1:0]   r_ms [3];
    logic [2:0]        r_neg2;
    logic              r_zero2;
    logic [SQ_W-1:0]   r_sq [3];
    logic [SUM_W-1:0]  r_sum;
    logic [NUM_W-1:0]  r_num [3];
    logic [ROOT_W-1:0] r_den;

    logic [W-1:0]      orv;
    logic [LZ_W-1:0]   lead;
    logic [7:0]        lead8;
    logic [XW-1:0]     sh [3];
    logic [ROOT_W-1:0] root;
    logic [3*MS_W-1:0] m_late;
    logic [3:0]        sgn_late;
    logic [Q_W-1:0]    quo [3];

    // Largest magnitude has the same leading one as the OR of all three.
    always_comb begin
        orv  = r_m0[0] | r_m0[1] | r_m0[2];
        lead = '0;
        for (int i = 0; i < W; i++) begin
            if (orv[i]) begin
                lead = LZ_W'(i);
            end
        end
    end

    always_comb begin
        lead8 = 8'(r_lead);
        for (int i = 0; i < 3; i++) begin
            if (lead8 > 8'(LEAD_POS)) begin
                sh[i] = XW'(r_m1[i]) >> (lead8 - 8'(LEAD_POS));
            end else begin
                sh[i] = XW'(r_m1[i]) << (8'(LEAD_POS) - lead8);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_neg0[i] <= i_v[i][W-1];
            r_m0[i]   <= i_v[i][W-1] ? W'(-i_v[i]) : W'(i_v[i]);
            r_m1[i]   <= r_m0[i];
            r_ms[i]   <= sh[i][MS_W-1:0];
            r_sq[i]   <= SQ_W'(r_ms[i]) * SQ_W'(r_ms[i]);
        end
        r_neg1  <= r_neg0;
        r_lead  <= lead;
        r_nz1   <= |orv;
        r_neg2  <= r_neg1;
        r_zero2 <= !r_nz1;
        r_sum   <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    end

    for (genvar i = 0; i < 3; i++) begin : g_w
        assign o_w[i] = r_neg2[i] ? -$signed({1'b0, r_ms[i]}) : $signed({1'b0, r_ms[i]});
    end

    fnf_isqrt u_isqrt (
        .i_clk (i_clk),
        .i_s   (r_sum),
        .o_r   (root)
    );

    fnf_delay #(.W(3*MS_W), .D(SQ_STEPS + 2)) u_m_dly (
        .i_clk (i_clk),
        .i_d   ({r_ms[0], r_ms[1], r_ms[2]}),
        .o_q   (m_late)
    );

    fnf_delay #(.W(4), .D(SQ_STEPS + DIV_STEPS + 3)) u_sgn_dly (
        .i_clk (i_clk),
        .i_d   ({r_neg2, r_zero2}),
        .o_q   (sgn_late)
    );

    // Dividend carries half the root so the quotient rounds to nearest.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_num[i] <= {m_late[(2-i)*MS_W +: MS_W], 14'b0} + NUM_W'(root >> 1);
        end
        r_den <= root;
    end

    fnf_div u_div (
        .i_clk (i_clk),
        .i_num (r_num),
        .i_den (r_den),
        .o_q   (quo)
    );

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (sgn_late[0]) begin
                o_a[i] <= '0;
            end else if (sgn_late[1 + i]) begin
                o_a[i] <= -$signed({1'b0, quo[i]});
            end else begin
                o_a[i] <= $signed({1'b0, quo[i]});
            end
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the surface normal frame pipeline.
module testbench import fnf_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // One input word: the normal and the point.
    typedef struct {
        logic signed [NRM_W-1:0] nrm[3];
        logic signed [POS_W-1:0] pos[3];
    } t_sample;

    // One result word: nine axis components (axis1, axis2, axis3) and the translation.
    typedef struct {
        logic [AX_W-1:0]  ax[9];
        logic [POS_W-1:0] tr[3];
    } t_frame;

    // Drain margin, longer than the block takes to return any word that it takes.
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 200000;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    logic o_busy;
    logic signed [NRM_W-1:0] i_normal_x, i_normal_y, i_normal_z;
    logic signed [POS_W-1:0] i_pos_x, i_pos_y, i_pos_z;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [EPS_W-1:0] i_cfg_axis_epsilon;
    logic o_valid;
    logic signed [AX_W-1:0] o_axis1_x, o_axis1_y, o_axis1_z;
    logic signed [AX_W-1:0] o_axis2_x, o_axis2_y, o_axis2_z;
    logic signed [AX_W-1:0] o_axis3_x, o_axis3_y, o_axis3_z;
    logic signed [POS_W-1:0] o_trans_x, o_trans_y, o_trans_z;

    frame_from_surface_normal u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_normal_x(i_normal_x), .i_normal_y(i_normal_y), .i_normal_z(i_normal_z),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_axis_epsilon(i_cfg_axis_epsilon),
        .o_valid(o_valid),
        .o_axis1_x(o_axis1_x), .o_axis1_y(o_axis1_y), .o_axis1_z(o_axis1_z),
        .o_axis2_x(o_axis2_x), .o_axis2_y(o_axis2_y), .o_axis2_z(o_axis2_z),
        .o_axis3_x(o_axis3_x), .o_axis3_y(o_axis3_y), .o_axis3_z(o_axis3_z),
        .o_trans_x(o_trans_x), .o_trans_y(o_trans_y), .o_trans_z(o_trans_z)
    );

    // Words waiting to be sent, frames waiting to come back, and our copy of the register.
    t_sample         pending_words[$];
    t_frame          frames_due[$];
    logic [EPS_W-1:0] eps_copy;
    int              mismatches;
    int              cycle_count;
    logic            took_last;   // the word on the inputs was taken at the last edge
    int              burst_left;
    int              gap_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Integer square root, one result bit per step, rounding down.
    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Scales a vector to unit length in Q2.14. The magnitudes are first brought so that the
    // largest one has its leading one at bit 29; that shifted vector is also handed back,
    // since the cross product for the second axis works on it.
    function automatic void to_unit(input longint v[3], output logic [AX_W-1:0] q[3],
                                    output longint w[3]);
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned root;
        longint unsigned quo;
        bit              neg[3];
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            m[i]   = neg[i] ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) begin
                q[i] = '0;
                w[i] = 0;
            end
            return;
        end
        while (mx >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            mx >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            mx <<= 1;
        end
        sum  = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        root = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            quo  = ((m[i] << 14) + (root >> 1)) / root;
            q[i] = neg[i] ? AX_W'(-quo) : AX_W'(quo);
            w[i] = neg[i] ? -longint'(m[i]) : longint'(m[i]);
        end
    endfunction

    // Works out the frame the block must return for one word under threshold eps.
    function automatic t_frame frame_of(t_sample s, logic [EPS_W-1:0] eps);
        t_frame f;
        longint n[3], pm[3], u[3], t[3], w[3], unused[3];
        logic [AX_W-1:0] a1[3], a2[3], a3[3];
        longint mag;
        t_axis  k_axis;
        for (int i = 0; i < 3; i++) begin
            n[i]  = s.nrm[i];
            pm[i] = longint'(s.pos[i]) - 65536;
        end
        // The first of x and y whose magnitude exceeds the threshold solves the plane
        // equation; when neither does, z is used whatever its size.
        k_axis = AX_Z;
        for (int i = 1; i >= 0; i--) begin
            mag = n[i] < 0 ? -n[i] : n[i];
            if (mag > longint'(eps)) k_axis = t_axis'(i);
        end
        for (int i = 0; i < 3; i++) u[i] = (i == int'(k_axis)) ? 0 : -n[k_axis] * pm[i];
        for (int i = 0; i < 3; i++)
            if (i != int'(k_axis)) u[k_axis] += n[i] * pm[i];
        // Direction was scaled by the solving component; undo its sign.
        if (n[k_axis] < 0)
            for (int i = 0; i < 3; i++) u[i] = -u[i];
        to_unit(u, a1, w);
        t[0] = n[1] * w[2] - n[2] * w[1];
        t[1] = n[2] * w[0] - n[0] * w[2];
        t[2] = n[0] * w[1] - n[1] * w[0];
        to_unit(t, a2, unused);
        to_unit(n, a3, unused);
        for (int i = 0; i < 3; i++) begin
            f.ax[i]     = a1[i];
            f.ax[3 + i] = a2[i];
            f.ax[6 + i] = a3[i];
            f.tr[i]     = s.pos[i];
        end
        return f;
    endfunction

    // Input side, sampled at the rising edge: a word taken now gets its frame predicted.
    always @(posedge i_clk) begin
        t_sample s;
        cycle_count <= cycle_count + 1;
        took_last   <= i_rst_n && i_start && !o_busy;
        if (i_rst_n && i_start && !o_busy) begin
            s.nrm[0] = i_normal_x;
            s.nrm[1] = i_normal_y;
            s.nrm[2] = i_normal_z;
            s.pos[0] = i_pos_x;
            s.pos[1] = i_pos_y;
            s.pos[2] = i_pos_z;
            frames_due.push_back(frame_of(s, eps_copy));
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) eps_copy <= i_cfg_axis_epsilon;
    end

    // Result side: every strobed word is checked against the oldest frame still due.
    always @(posedge i_clk) begin
        t_frame got;
        t_frame want;
        bit     bad;
        if (i_rst_n && o_valid) begin
            got.ax = '{o_axis1_x, o_axis1_y, o_axis1_z, o_axis2_x, o_axis2_y, o_axis2_z,
                       o_axis3_x, o_axis3_y, o_axis3_z};
            got.tr = '{o_trans_x, o_trans_y, o_trans_z};
            if (frames_due.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycle_count);
            end else begin
                want = frames_due.pop_front();
                bad  = 0;
                for (int i = 0; i < 9; i++) bad |= got.ax[i] !== want.ax[i];
                for (int i = 0; i < 3; i++) bad |= got.tr[i] !== want.tr[i];
                if (bad) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("frame mismatch at cycle %0d", cycle_count);
                        for (int i = 0; i < 9; i++)
                            if (got.ax[i] !== want.ax[i])
                                $display("  axis%0d[%0d]: expected %h, got %h",
                                         i / 3 + 1, i % 3, want.ax[i], got.ax[i]);
                        for (int i = 0; i < 3; i++)
                            if (got.tr[i] !== want.tr[i])
                                $display("  trans[%0d]: expected %h, got %h",
                                         i, want.tr[i], got.tr[i]);
                    end
                end
            end
        end
    end

    // Sender: drives at the falling edge in bursts with random gaps. A word stays on the
    // inputs until it is taken, then the next one from the queue follows.
    always @(negedge i_clk) begin
        t_sample s;
        if (!i_rst_n || (i_start && !took_last)) begin
            // hold the current word
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_start  <= 1'b0;
        end else if (pending_words.size() != 0) begin
            s = pending_words.pop_front();
            i_normal_x <= s.nrm[0];
            i_normal_y <= s.nrm[1];
            i_normal_z <= s.nrm[2];
            i_pos_x    <= s.pos[0];
            i_pos_y    <= s.pos[1];
            i_pos_z    <= s.pos[2];
            i_start    <= 1'b1;
            if (burst_left <= 1) begin
                // Some bursts run long with no gap at all.
                burst_left <= $urandom_range(1, 40);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_start <= 1'b0;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic signed [NRM_W-1:0] rand_comp(int flavor, logic [EPS_W-1:0] eps);
        logic signed [NRM_W-1:0] c;
        case (flavor)
            0: c = NRM_W'($urandom_range(0, 2 * int'(eps) + 2) - int'(eps) - 1); // near threshold
            1: c = NRM_W'($urandom_range(0, 6) - 3);                          // tiny or zero
            default: c = NRM_W'($urandom);                                    // anything
        endcase
        return c;
    endfunction

    function automatic t_sample rand_sample(logic [EPS_W-1:0] eps);
        t_sample s;
        for (int i = 0; i < 3; i++) begin
            s.nrm[i] = rand_comp(($urandom_range(0, 9) < 6) ? 2 : $urandom_range(0, 1), eps);
            case ($urandom_range(0, 5))
                0:       s.pos[i] = 32'sd65536 + $urandom_range(0, 4) - 2;  // near one
                1:       s.pos[i] = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
                2:       s.pos[i] = $urandom_range(0, 1 << 20) - (1 << 19);
                default: s.pos[i] = $urandom;
            endcase
        end
        return s;
    endfunction

    function automatic t_sample make(int nx, int ny, int nz, int px, int py, int pz);
        t_sample s;
        s.nrm = '{NRM_W'(nx), NRM_W'(ny), NRM_W'(nz)};
        s.pos = '{px, py, pz};
        return s;
    endfunction

    // Writes the threshold while nothing is in flight, then waits for the handshake.
    task automatic set_threshold(logic [EPS_W-1:0] eps);
        @(negedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_axis_epsilon <= eps;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sender pause: nothing left to send, nothing still due, then the pipeline drains.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || i_start || frames_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(logic [EPS_W-1:0] eps, int count);
        set_threshold(eps);
        for (int i = 0; i < count; i++) pending_words.push_back(rand_sample(eps));
        wait_idle();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_start            = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_axis_epsilon = '0;
        i_normal_x         = '0;
        i_normal_y         = '0;
        i_normal_z         = '0;
        i_pos_x            = '0;
        i_pos_y            = '0;
        i_pos_z            = '0;
        eps_copy           = '0;
        mismatches         = 0;
        cycle_count        = 0;
        took_last          = 1'b0;
        burst_left         = 0;
        gap_left           = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words under the reset threshold of zero.
        pending_words.push_back(make(0, 0, 0, 0, 0, 0));                // zero normal
        pending_words.push_back(make(16384, 0, 0, 65536, 65536, 65536)); // point is on q
        pending_words.push_back(make(16384, 0, 0, 0, 0, 0));
        pending_words.push_back(make(-16384, 0, 0, 3 << 16, -7 << 16, 5));
        pending_words.push_back(make(0, 16384, 0, 1, 2, 3));
        pending_words.push_back(make(0, -16384, 0, -1, -2, -3));
        pending_words.push_back(make(0, 0, 16384, 100000, -200000, 300000));
        pending_words.push_back(make(0, 0, -16384, 100000, -200000, 300000));
        pending_words.push_back(make(32767, 32767, 32767,
                                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        pending_words.push_back(make(-32768, -32768, -32768,
                                     32'h80000000, 32'h80000000, 32'h80000000));
        pending_words.push_back(make(-32768, 32767, 0, 32'h80000000, 32'h7fffffff, 0));
        pending_words.push_back(make(1, -1, 1, 12345, -54321, 99));
        pending_words.push_back(make(9459, 9459, 9459, 0, 65536, 131072));
        pending_words.push_back(make(0, 3, -5, 65536, 65536, 65536));
        pending_words.push_back(make(11585, -11585, 0, 0, 0, 0));      // cross product check
        wait_idle();

        // Largest threshold: only components of magnitude above 16383 qualify; else z solves, zero or not.
        set_threshold(16383);
        pending_words.push_back(make(16383, 16383, 0, 5, 6, 7));
        pending_words.push_back(make(16384, 16384, 0, 5, 6, 7));
        pending_words.push_back(make(-16384, 100, 2, 5, 6, 7));
        pending_words.push_back(make(100, -32768, 0, 5, 6, 7));
        pending_words.push_back(make(0, 0, -16383, 5, 6, 7));
        wait_idle();
        random_phase(16383, 150);

        // Thresholds of assorted size; some random components cluster near each one.
        random_phase(0, 300);
        random_phase(5, 150);
        random_phase(14'($urandom), 150);
        random_phase(200, 200);

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
